FILE: rtl/voxel_grid_ray_traversal_defines.svh
// Assertion macros for the voxel ray traversal block.
`ifndef VOXEL_GRID_RAY_TRAVERSAL_DEFINES_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication
`define VGRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication
`define VGRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define VGRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VGRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/vgrt_pkg.sv
`timescale 1ns / 1ps

package vgrt_pkg;

    // Default chunk size and step limit
    localparam int DEF_SIZE_X    = 16;
    localparam int DEF_SIZE_Y    = 128;
    localparam int DEF_SIZE_Z    = 16;
    localparam int DEF_MAX_STEPS = 128;

    // Field widths
    localparam int VX_W  = 4;
    localparam int VY_W  = 7;
    localparam int VZ_W  = 4;
    localparam int ORG_W = 18;
    localparam int DIR_W = 16;
    localparam int FACE_W = 3;

    // Origin bias of 0.01 in Q.16
    localparam int BIAS_Q16 = 655;

    // Reciprocal divider: 2^30 / |dir| gives a 31-bit quotient, one bit a cycle
    localparam int DIV_STEPS = 31;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    // Axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // Entered-face codes
    localparam logic [FACE_W-1:0] FC_FRONT  = 3'd0;
    localparam logic [FACE_W-1:0] FC_BACK   = 3'd1;
    localparam logic [FACE_W-1:0] FC_LEFT   = 3'd2;
    localparam logic [FACE_W-1:0] FC_RIGHT  = 3'd3;
    localparam logic [FACE_W-1:0] FC_TOP    = 3'd4;
    localparam logic [FACE_W-1:0] FC_BOTTOM = 3'd5;

    typedef struct packed {
        logic                     kind;
        logic [VX_W-1:0]          vox_x;
        logic [VY_W-1:0]          vox_y;
        logic [VZ_W-1:0]          vox_z;
        logic                     solid;
        logic signed [ORG_W-1:0]  origin_x;
        logic signed [ORG_W-1:0]  origin_y;
        logic signed [ORG_W-1:0]  origin_z;
        logic signed [DIR_W-1:0]  dir_x;
        logic signed [DIR_W-1:0]  dir_y;
        logic signed [DIR_W-1:0]  dir_z;
    } t_item;

    typedef struct packed {
        logic              hit;
        logic [VX_W-1:0]   hit_x;
        logic [VY_W-1:0]   hit_y;
        logic [VZ_W-1:0]   hit_z;
        logic [FACE_W-1:0] face;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic wr;
        logic load;
        logic div;
        logic div_first;
        logic setup;
        logic step;
        logic res_hit;
        logic res_miss;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hit;
    } t_status;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_SETUP = 6'b001000,
        S_TRAV  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

endpackage

FILE: rtl/vgrt_item_if.sv
`timescale 1ns / 1ps

interface vgrt_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [vgrt_pkg::VX_W-1:0]             vox_x;
    logic [vgrt_pkg::VY_W-1:0]             vox_y;
    logic [vgrt_pkg::VZ_W-1:0]             vox_z;
    logic                                  solid;
    logic signed [vgrt_pkg::ORG_W-1:0]     origin_x;
    logic signed [vgrt_pkg::ORG_W-1:0]     origin_y;
    logic signed [vgrt_pkg::ORG_W-1:0]     origin_z;
    logic signed [vgrt_pkg::DIR_W-1:0]     dir_x;
    logic signed [vgrt_pkg::DIR_W-1:0]     dir_y;
    logic signed [vgrt_pkg::DIR_W-1:0]     dir_z;

    modport source (
        output valid, kind, vox_x, vox_y, vox_z, solid,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, kind, vox_x, vox_y, vox_z, solid,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

FILE: rtl/vgrt_res_if.sv
`timescale 1ns / 1ps

interface vgrt_res_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [vgrt_pkg::VX_W-1:0]      hit_x;
    logic [vgrt_pkg::VY_W-1:0]      hit_y;
    logic [vgrt_pkg::VZ_W-1:0]      hit_z;
    logic [vgrt_pkg::FACE_W-1:0]    face;

    modport source (output valid, hit, hit_x, hit_y, hit_z, face, input ready);
    modport sink   (input valid, hit, hit_x, hit_y, hit_z, face, output ready);
endinterface

FILE: rtl/voxel_grid_ray_traversal.sv
// Write item: the map is updated at the edge that accepts it; no result.
// Cast item: accept, bit-serial reciprocal divider per axis, setup, a walk of up to
// MAX_STEPS steps (one map read per step), then output once the output register is free.
// One item at a time; the next is taken once the result sits in the output register.
// Reset: synchronous, active low; then a clearing pass over the SIZE_X*SIZE_Y*SIZE_Z map
// voxels (32768 by default) sets every voxel to air while no item is accepted.
`timescale 1ns / 1ps
`include "voxel_grid_ray_traversal_defines.svh"

module voxel_grid_ray_traversal #(
    parameter int SIZE_X    = vgrt_pkg::DEF_SIZE_X,
    parameter int SIZE_Y    = vgrt_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z    = vgrt_pkg::DEF_SIZE_Z,
    parameter int MAX_STEPS = vgrt_pkg::DEF_MAX_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vgrt_item_if.sink   i_item,
    vgrt_res_if.source  o_res
);
    vgrt_pkg::t_cmd    dp_cmd;
    vgrt_pkg::t_status dp_st;
    vgrt_pkg::t_item   c_item;
    vgrt_pkg::t_res    c_res;
    logic              c_in_ready;
    logic              c_out_valid;

    // Pack the input payload
    assign c_item = '{kind: i_item.kind, vox_x: i_item.vox_x, vox_y: i_item.vox_y,
                      vox_z: i_item.vox_z, solid: i_item.solid,
                      origin_x: i_item.origin_x, origin_y: i_item.origin_y,
                      origin_z: i_item.origin_z, dir_x: i_item.dir_x,
                      dir_y: i_item.dir_y, dir_z: i_item.dir_z};

    vgrt_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_kind   (i_item.kind),
        .i_out_ready (o_res.ready),
        .i_st        (dp_st),
        .o_in_ready  (c_in_ready),
        .o_out_valid (c_out_valid),
        .o_cmd       (dp_cmd)
    );

    vgrt_datapath #(
        .SIZE_X    (SIZE_X),
        .SIZE_Y    (SIZE_Y),
        .SIZE_Z    (SIZE_Z),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_item  (c_item),
        .o_st    (dp_st),
        .o_res   (c_res)
    );

    assign i_item.ready = c_in_ready;
    assign o_res.valid  = c_out_valid;
    assign o_res.hit    = c_res.hit;
    assign o_res.hit_x  = c_res.hit_x;
    assign o_res.hit_y  = c_res.hit_y;
    assign o_res.hit_z  = c_res.hit_z;
    assign o_res.face   = c_res.face;

    // A cast keeps the input closed while it runs
    `VGRT_ASSERT_NXT(a_cast_busy, i_clk, i_rst_n, i_item.valid && i_item.ready && i_item.kind == vgrt_pkg::KIND_CAST, !i_item.ready)
    // A loaded result is offered on the next cycle
    `VGRT_ASSERT_NXT(a_out_offer, i_clk, i_rst_n, dp_cmd.out_load, o_res.valid)
    // A pending solid voxel is only seen when the walk takes it as the hit
    `VGRT_ASSERT_IMP(a_hit_taken, i_clk, i_rst_n, dp_st.hit, dp_cmd.res_hit)
endmodule

FILE: rtl/vgrt_ram.sv
`timescale 1ns / 1ps

// Single-port RAM, registered read
module vgrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/vgrt_ctrl.sv
`timescale 1ns / 1ps

module vgrt_ctrl #(
    parameter int MAX_STEPS = vgrt_pkg::DEF_MAX_STEPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    input  logic              i_out_ready,
    input  vgrt_pkg::t_status i_st,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output vgrt_pkg::t_cmd    o_cmd
);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    vgrt_pkg::t_state               r_state, n_state;
    logic [vgrt_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [CNT_W-1:0]               r_step_cnt, n_step_cnt;
    logic                           r_out_valid, n_out_valid;
    vgrt_pkg::t_cmd                 c_cmd;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        n_step_cnt = r_step_cnt;
        c_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            vgrt_pkg::S_CLEAR: begin
                c_cmd.clear = 1'b1;
                if (i_st.clr_last) begin
                    n_state = vgrt_pkg::S_IDLE;
                end
            end
            vgrt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == vgrt_pkg::KIND_WRITE) begin
                        c_cmd.wr = 1'b1;
                    end else begin
                        c_cmd.load = 1'b1;
                        n_div_cnt  = '0;
                        n_state    = vgrt_pkg::S_DIV;
                    end
                end
            end
            vgrt_pkg::S_DIV: begin
                c_cmd.div       = 1'b1;
                c_cmd.div_first = (r_div_cnt == '0);
                n_div_cnt       = r_div_cnt + 1'b1;
                if (r_div_cnt == vgrt_pkg::DIV_CNT_W'(vgrt_pkg::DIV_STEPS - 1)) begin
                    n_state = vgrt_pkg::S_SETUP;
                end
            end
            vgrt_pkg::S_SETUP: begin
                c_cmd.setup = 1'b1;
                n_step_cnt  = '0;
                n_state     = vgrt_pkg::S_TRAV;
            end
            vgrt_pkg::S_TRAV: begin
                // Check the voxel read last cycle, then take the next step
                if (i_st.hit) begin
                    c_cmd.res_hit = 1'b1;
                    n_state       = vgrt_pkg::S_OUT;
                end else if (r_step_cnt == CNT_W'(MAX_STEPS)) begin
                    c_cmd.res_miss = 1'b1;
                    n_state        = vgrt_pkg::S_OUT;
                end else begin
                    c_cmd.step = 1'b1;
                    n_step_cnt = r_step_cnt + 1'b1;
                end
            end
            vgrt_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    c_cmd.out_load = 1'b1;
                    n_state        = vgrt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vgrt_pkg::S_CLEAR;
            end
        endcase
        n_out_valid = c_cmd.out_load | (r_out_valid & ~i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vgrt_pkg::S_CLEAR;
            r_div_cnt   <= '0;
            r_step_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_step_cnt  <= n_step_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = c_cmd;
    assign o_out_valid = r_out_valid;
endmodule

FILE: rtl/vgrt_datapath.sv
`timescale 1ns / 1ps

module vgrt_datapath #(
    parameter int SIZE_X    = vgrt_pkg::DEF_SIZE_X,
    parameter int SIZE_Y    = vgrt_pkg::DEF_SIZE_Y,
    parameter int SIZE_Z    = vgrt_pkg::DEF_SIZE_Z,
    parameter int MAX_STEPS = vgrt_pkg::DEF_MAX_STEPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vgrt_pkg::t_cmd    i_cmd,
    input  vgrt_pkg::t_item   i_item,
    output vgrt_pkg::t_status o_st,
    output vgrt_pkg::t_res    o_res
);
    localparam int VOXELS = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int ADDR_W = (VOXELS > 1) ? $clog2(VOXELS) : 1;
    // Start voxel lies in [-512, 512]; walk moves at most MAX_STEPS
    localparam int BLK_W  = $clog2(512 + MAX_STEPS) + 1;
    localparam logic signed [BLK_W-1:0] LIM_X = BLK_W'(SIZE_X);
    localparam logic signed [BLK_W-1:0] LIM_Y = BLK_W'(SIZE_Y);
    localparam logic signed [BLK_W-1:0] LIM_Z = BLK_W'(SIZE_Z);

    // Per-axis lanes
    logic signed [BLK_W-1:0] r_blk   [3];
    logic [15:0]             r_frac  [3];
    logic                    r_neg   [3];
    logic                    r_idle  [3];
    logic [15:0]             r_mag   [3];
    logic [16:0]             r_rem   [3];
    logic [30:0]             r_q     [3];
    logic [31:0]             r_delta [3];
    logic [31:0]             r_side  [3];

    // Pending voxel check, result and output registers
    logic                              r_pend_in;
    logic [vgrt_pkg::VX_W-1:0]         r_pend_x;
    logic [vgrt_pkg::VY_W-1:0]         r_pend_y;
    logic [vgrt_pkg::VZ_W-1:0]         r_pend_z;
    logic [vgrt_pkg::FACE_W-1:0]       r_pend_face;
    vgrt_pkg::t_res                    r_res;
    vgrt_pkg::t_res                    r_out;
    logic [ADDR_W-1:0]                 r_clr_addr;

    logic signed [vgrt_pkg::ORG_W-1:0] c_org  [3];
    logic signed [vgrt_pkg::DIR_W-1:0] c_dir  [3];
    logic [26:0]                       c_pos  [3];
    logic [16:0]                       c_rsh  [3];
    logic                              c_ge   [3];
    logic [16:0]                       c_dist [3];
    logic [47:0]                       c_prod [3];
    logic [32:0]                       c_key  [3];
    logic [32:0]                       c_ssum [3];
    logic signed [BLK_W-1:0]           c_nb   [3];
    logic [1:0]                        c_ax;
    logic [vgrt_pkg::FACE_W-1:0]       c_face;
    logic                              c_in;
    logic                              c_win;
    logic [ADDR_W-1:0]                 c_raddr;
    logic [ADDR_W-1:0]                 c_waddr;
    logic                              c_we;
    logic [ADDR_W-1:0]                 c_addr;
    logic                              c_wdata;
    logic                              c_rdata;

    assign c_org[0] = i_item.origin_x;
    assign c_org[1] = i_item.origin_y;
    assign c_org[2] = i_item.origin_z;
    assign c_dir[0] = i_item.dir_x;
    assign c_dir[1] = i_item.dir_y;
    assign c_dir[2] = i_item.dir_z;

    // Lane arithmetic: biased origin, divider step, side distance, keys
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            c_pos[a]  = ({{9{c_org[a][vgrt_pkg::ORG_W-1]}}, c_org[a]} << 8)
                        + 27'(vgrt_pkg::BIAS_Q16);
            c_rsh[a]  = {r_rem[a][15:0], i_cmd.div_first};
            c_ge[a]   = (c_rsh[a] >= {1'b0, r_mag[a]});
            c_dist[a] = r_neg[a] ? {1'b0, r_frac[a]} : (17'h10000 - {1'b0, r_frac[a]});
            c_prod[a] = 48'(c_dist[a]) * 48'(r_q[a]);
            c_key[a]  = {r_idle[a], r_side[a]};
            c_ssum[a] = {1'b0, r_side[a]} + {1'b0, r_delta[a]};
        end
    end

    // Axis choice: x if strictly smallest, else y if below z, else z
    always_comb begin
        if ((c_key[0] < c_key[1]) && (c_key[0] < c_key[2])) begin
            c_ax = vgrt_pkg::AX_X;
        end else if (c_key[1] < c_key[2]) begin
            c_ax = vgrt_pkg::AX_Y;
        end else begin
            c_ax = vgrt_pkg::AX_Z;
        end
        for (int a = 0; a < 3; a++) begin
            if (c_ax == 2'(a)) begin
                c_nb[a] = r_neg[a] ? (r_blk[a] - BLK_W'(1)) : (r_blk[a] + BLK_W'(1));
            end else begin
                c_nb[a] = r_blk[a];
            end
        end
        case (c_ax)
            vgrt_pkg::AX_X: c_face = r_neg[0] ? vgrt_pkg::FC_RIGHT : vgrt_pkg::FC_LEFT;
            vgrt_pkg::AX_Y: c_face = r_neg[1] ? vgrt_pkg::FC_TOP : vgrt_pkg::FC_BOTTOM;
            default:        c_face = r_neg[2] ? vgrt_pkg::FC_FRONT : vgrt_pkg::FC_BACK;
        endcase
    end

    // Map addressing for the clear sweep, the walk and writes
    always_comb begin
        c_in = !c_nb[0][BLK_W-1] && (c_nb[0] < LIM_X)
            && !c_nb[1][BLK_W-1] && (c_nb[1] < LIM_Y)
            && !c_nb[2][BLK_W-1] && (c_nb[2] < LIM_Z);
        c_raddr = (ADDR_W'(c_nb[0]) * ADDR_W'(SIZE_Y) + ADDR_W'(c_nb[1]))
                  * ADDR_W'(SIZE_Z) + ADDR_W'(c_nb[2]);
        c_win = (32'(i_item.vox_x) < SIZE_X) && (32'(i_item.vox_y) < SIZE_Y)
             && (32'(i_item.vox_z) < SIZE_Z);
        c_waddr = (ADDR_W'(i_item.vox_x) * ADDR_W'(SIZE_Y) + ADDR_W'(i_item.vox_y))
                  * ADDR_W'(SIZE_Z) + ADDR_W'(i_item.vox_z);
        if (i_cmd.clear) begin
            c_we    = 1'b1;
            c_addr  = r_clr_addr;
            c_wdata = 1'b0;
        end else if (i_cmd.wr) begin
            c_we    = c_win;
            c_addr  = c_waddr;
            c_wdata = i_item.solid;
        end else begin
            c_we    = 1'b0;
            c_addr  = c_raddr;
            c_wdata = 1'b0;
        end
    end

    vgrt_ram #(
        .WIDTH (1),
        .DEPTH (VOXELS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_addr  (c_addr),
        .i_wdata (c_wdata),
        .o_rdata (c_rdata)
    );

    // Control registers: clear sweep and pending-check flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_pend_in  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.setup || i_cmd.res_hit || i_cmd.res_miss) begin
                r_pend_in <= 1'b0;
            end else if (i_cmd.step) begin
                r_pend_in <= c_in;
            end
        end
    end

    // Lane registers
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            if (i_cmd.load) begin
                r_blk[a]  <= BLK_W'(signed'(c_pos[a][26:16]));
                r_frac[a] <= c_pos[a][15:0];
                r_neg[a]  <= c_dir[a][vgrt_pkg::DIR_W-1];
                r_idle[a] <= (c_dir[a] == '0);
                r_mag[a]  <= c_dir[a][vgrt_pkg::DIR_W-1] ? 16'(-c_dir[a]) : 16'(c_dir[a]);
                r_rem[a]  <= '0;
            end
            if (i_cmd.div) begin
                r_rem[a] <= c_ge[a] ? (c_rsh[a] - {1'b0, r_mag[a]}) : c_rsh[a];
                r_q[a]   <= {r_q[a][29:0], c_ge[a]};
            end
            if (i_cmd.setup) begin
                r_side[a]  <= r_idle[a] ? vgrt_pkg::SAT32 : c_prod[a][47:16];
                r_delta[a] <= r_idle[a] ? vgrt_pkg::SAT32 : {1'b0, r_q[a]};
            end
            if (i_cmd.step && (c_ax == 2'(a))) begin
                r_blk[a]  <= c_nb[a];
                r_side[a] <= c_ssum[a][32] ? vgrt_pkg::SAT32 : c_ssum[a][31:0];
            end
        end
    end

    // Pending voxel, result and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_pend_x    <= c_nb[0][vgrt_pkg::VX_W-1:0];
            r_pend_y    <= c_nb[1][vgrt_pkg::VY_W-1:0];
            r_pend_z    <= c_nb[2][vgrt_pkg::VZ_W-1:0];
            r_pend_face <= c_face;
        end
        if (i_cmd.res_hit) begin
            r_res <= '{hit: 1'b1, hit_x: r_pend_x, hit_y: r_pend_y,
                       hit_z: r_pend_z, face: r_pend_face};
        end else if (i_cmd.res_miss) begin
            r_res <= '0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_st.hit      = r_pend_in & c_rdata;
    assign o_st.clr_last = (r_clr_addr == ADDR_W'(VOXELS - 1));
    assign o_res         = r_out;
endmodule
